### hw/rtl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants of the compensated current drive.
// ----------------------------------------------------------------------------
package ccd_pkg;

    localparam int DAC_WIDTH_DEF   = 12;
    localparam int MAX_FREQ_DEF    = 100;

    localparam int SP_W            = 12;        // setpoint register
    localparam int GAIN_W          = 17;        // Q1.16 gain
    localparam int RAW_W           = 16;
    localparam int TOT_W           = 16;
    localparam int TIME_W          = 32;
    localparam int PER_W           = 20;        // period in us, up to 1e6
    localparam int FRQ_W           = 7;
    localparam int DUTY_W          = 7;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int TGT_W           = 29;        // setpoint * 105600
    localparam int QUEUE_DEPTH     = 2;

    localparam int GAIN_ONE        = 65536;
    localparam int GAIN_LOW        = 45875;
    localparam int GAIN_HIGH       = 85197;
    localparam int GAIN_EFF_LO     = 32768;
    localparam int GAIN_EFF_HI     = 98304;
    localparam int TGT_K           = 105600;
    localparam int US_PER_S        = 1000000;
    localparam int DUTY_MAX        = 100;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT  = 3'd0,
        CFG_FREQ      = 3'd1,
        CFG_DUTY      = 3'd2,
        CFG_PULSE     = 3'd3,
        CFG_SRC_EN    = 3'd4,
        CFG_COMP_EN   = 3'd5,
        CFG_INHIBIT   = 3'd6,
        CFG_GAIN_INIT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  time_us;
        logic [TOT_W-1:0]   total;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMP_GO,
        ST_AMP_DIV,
        ST_PER_DIV,
        ST_HIGH_GO,
        ST_HIGH_DIV,
        ST_TICK_DIV,
        ST_SMP_LOAD,
        ST_SMP_CHECK,
        ST_SMP_MUL,
        ST_SMP_SUM,
        ST_GAIN_DIV,
        ST_OUT
    } t_state;

endpackage

### hw/rtl/compensated_current_drive.sv
// ----------------------------------------------------------------------------
// compensated_current_drive
// Current DAC driver with pulse timing and outer-loop gain compensation.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): op 0 is a time tick with a microsecond
// stamp, op 1 a pair of shunt readings. Every item gives one result on the
// output channel (o_valid / i_stall) carrying the DAC code, a write strobe,
// the present gain, the measured current and an adjustment flag.
// Settings go in through a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data), one register per write; the user must write them only
// while no item is in flight, as the block itself does not enforce it.
// Items pass through a two-entry queue to a sequencer built round a shared
// one-bit-per-cycle divider. Continuous ticks and ignored samples go
// straight to the output; a checked sample passes a load and a check state.
// A pulsed tick divides its timestamp by the period (timestamp modulo
// period); a compensating sample divides for the gain ratio, then for
// setpoint/gain. A setting write that changes setpoint, mode, gain,
// frequency or duty is worked off before the next item starts.
// Synchronous reset loads the register defaults, gain 1.0 and an empty
// queue. A stalled result is held in the output register; the queue keeps
// taking items until it fills, then o_stall rises.
// ----------------------------------------------------------------------------
module compensated_current_drive
    import ccd_pkg::*;
#(
    parameter int DAC_WIDTH   = DAC_WIDTH_DEF,
    parameter int MAX_FREQ_HZ = MAX_FREQ_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_op,
    input  logic [TIME_W-1:0]       i_time_us,
    input  logic signed [RAW_W-1:0] i_shunt_one_raw,
    input  logic signed [RAW_W-1:0] i_shunt_two_raw,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [DAC_WIDTH-1:0]    o_dac_code,
    output logic                    o_dac_write,
    output logic [GAIN_W-1:0]       o_gain_value,
    output logic [TOT_W-1:0]        o_total_current,
    output logic                    o_gain_adjusted,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    logic q_full;
    logic q_nonempty;
    logic q_push;
    logic q_pop;
    t_job front_job;
    t_job back_job;

    ccd_front u_front (
        .i_valid         (i_valid),
        .i_op            (i_op),
        .i_time_us       (i_time_us),
        .i_shunt_one_raw (i_shunt_one_raw),
        .i_shunt_two_raw (i_shunt_two_raw),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (q_push),
        .o_job           (front_job)
    );

    ccd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_job      (front_job),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_job      (back_job)
    );

    ccd_back #(
        .DAC_WIDTH   (DAC_WIDTH),
        .MAX_FREQ_HZ (MAX_FREQ_HZ)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_q_nonempty    (q_nonempty),
        .i_job           (back_job),
        .o_q_pop         (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_dac_code      (o_dac_code),
        .o_dac_write     (o_dac_write),
        .o_gain_value    (o_gain_value),
        .o_total_current (o_total_current),
        .o_gain_adjusted (o_gain_adjusted)
    );

endmodule

### hw/rtl/ccd_front.sv
// ----------------------------------------------------------------------------
// ccd_front
// Input side: takes items, clips and sums shunt readings, builds a job.
// ----------------------------------------------------------------------------
module ccd_front
    import ccd_pkg::*;
(
    input  logic                    i_valid,
    input  logic                    i_op,
    input  logic [TIME_W-1:0]       i_time_us,
    input  logic signed [RAW_W-1:0] i_shunt_one_raw,
    input  logic signed [RAW_W-1:0] i_shunt_two_raw,
    input  logic                    i_q_full,
    output logic                    o_stall,
    output logic                    o_push,
    output t_job                    o_job
);

    logic [RAW_W-2:0] one_clip;
    logic [RAW_W-2:0] two_clip;

    // negative readings count as zero
    assign one_clip = i_shunt_one_raw[RAW_W-1] ? '0 : i_shunt_one_raw[RAW_W-2:0];
    assign two_clip = i_shunt_two_raw[RAW_W-1] ? '0 : i_shunt_two_raw[RAW_W-2:0];

    assign o_stall       = i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_job.op      = t_op'(i_op);
    assign o_job.time_us = i_time_us;
    assign o_job.total   = TOT_W'(one_clip) + TOT_W'(two_clip);

endmodule

### hw/rtl/ccd_fifo.sv
// ----------------------------------------------------------------------------
// ccd_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ccd_fifo
    import ccd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_job;
                r_wr        <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/ccd_div.sv
// ----------------------------------------------------------------------------
// ccd_div
// Restoring divider, one quotient bit per cycle, shared by the back part.
// ----------------------------------------------------------------------------
module ccd_div
    import ccd_pkg::*;
#(
    parameter int NW = 53,
    parameter int DW = 34,
    parameter int SW = $clog2(NW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,    // dividend aligned to the top bits
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_steps,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    logic [NW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_acc[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quo  = r_acc;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == SW'(1)) && !i_start;
            if (i_start) begin
                r_acc <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_acc <= {r_acc[NW-2:0], ge};
                r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/ccd_back.sv
// ----------------------------------------------------------------------------
// ccd_back
// Execution side: settings, drive state, sequencer and result register.
// ----------------------------------------------------------------------------
module ccd_back
    import ccd_pkg::*;
#(
    parameter int DAC_WIDTH   = DAC_WIDTH_DEF,
    parameter int MAX_FREQ_HZ = MAX_FREQ_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_q_nonempty,
    input  t_job                 i_job,
    output logic                 o_q_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [DAC_WIDTH-1:0] o_dac_code,
    output logic                 o_dac_write,
    output logic [GAIN_W-1:0]    o_gain_value,
    output logic [TOT_W-1:0]     o_total_current,
    output logic                 o_gain_adjusted
);

    localparam int DAC_MAX = (1 << DAC_WIDTH) - 1;
    localparam int MEAS_K  = 3 * DAC_MAX;
    localparam int MEAS_W  = TOT_W + $clog2(MEAS_K + 1);
    localparam int MAX_TM  = (TGT_W + 5 > MEAS_W) ? TGT_W + 5 : MEAS_W;
    localparam int SUM_W   = MAX_TM + 1;
    localparam int SPLIT   = 18;
    localparam int HI_W    = SUM_W - SPLIT;
    localparam int PROD_W  = SUM_W + GAIN_W;
    localparam int NW      = PROD_W + 1;
    localparam int DW      = TGT_W + 5;
    localparam int SW      = $clog2(NW + 1);
    localparam int DIFF_W  = (TGT_W > MEAS_W) ? TGT_W : MEAS_W;
    localparam int FQ_W    = $clog2(MAX_FREQ_HZ + 1);
    localparam int AMP_K   = SP_W + 16;
    localparam int PER_K   = PER_W;
    localparam int HIGH_K  = PER_W + DUTY_W;
    localparam int TMIN    = 1600 * DAC_MAX;
    localparam int ETHR    = 320 * DAC_MAX;
    // floor(x / 100) as (x * M) >> S, exact for x below 2^30
    localparam longint unsigned DIV100_M = 64'd171798692;
    localparam int              DIV100_S = 34;

    // settings
    logic [SP_W-1:0]      r_setpoint;
    logic [FRQ_W-1:0]     r_freq;
    logic [DUTY_W-1:0]    r_duty;
    logic                 r_pulse;
    logic                 r_src_en;
    logic                 r_comp_en;
    logic                 r_inhibit;

    // drive state
    logic [GAIN_W-1:0]    r_gain;
    logic [DAC_WIDTH-1:0] r_amp;
    logic [DAC_WIDTH-1:0] r_last;
    logic                 r_written;
    logic [PER_W-1:0]     r_period;
    logic [PER_W-1:0]     r_high;
    logic [HIGH_K-1:0]    r_high_num;
    logic                 r_amp_pend;
    logic                 r_tim_pend;
    logic                 r_ret_out;

    // sample datapath
    logic [TOT_W-1:0]     r_total;
    logic [TGT_W-1:0]     r_target;
    logic [MEAS_W-1:0]    r_meas;
    logic [SUM_W-1:0]     r_sum;
    logic [DW-1:0]        r_den;
    logic [GAIN_W-1:0]    r_geff;
    logic [GAIN_W+SPLIT-1:0] r_plo;
    logic [GAIN_W+HI_W-1:0]  r_phi;

    // pending result
    logic [DAC_WIDTH-1:0] r_res_code;
    logic                 r_res_wr;
    logic [TOT_W-1:0]     r_res_total;
    logic                 r_res_adj;
    logic                 r_ovalid;

    t_state               r_state;
    t_state               n_state;

    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic [SW-1:0]        div_steps;
    logic                 div_done;
    logic [NW-1:0]        div_quo;
    logic [DW-1:0]        div_rem;

    logic [SP_W-1:0]      sp_used;
    logic [GAIN_W-1:0]    geff;
    logic [FQ_W-1:0]      f_used;
    logic [DUTY_W-1:0]    d_used;
    logic [AMP_K-1:0]     amp_num;
    logic [HIGH_K-1:0]    high_num;
    logic [DAC_WIDTH-1:0] tick_code;
    logic                 smp_active;
    logic [DIFF_W-1:0]    abs_err;
    logic                 smp_adj;
    logic [GAIN_W-1:0]    gain_new;
    logic                 out_free;
    logic                 idle_amp;
    logic                 idle_tim;

    ccd_div #(
        .NW (NW),
        .DW (DW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign sp_used = (32'(r_setpoint) > DAC_MAX) ? SP_W'(DAC_MAX) : r_setpoint;
    assign geff    = (r_gain > GAIN_W'(GAIN_EFF_LO) && r_gain < GAIN_W'(GAIN_EFF_HI))
                     ? r_gain : GAIN_W'(GAIN_ONE);
    assign f_used  = (r_freq == '0) ? FQ_W'(1) :
                     (32'(r_freq) > MAX_FREQ_HZ) ? FQ_W'(MAX_FREQ_HZ) : FQ_W'(r_freq);
    assign d_used  = (r_duty > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : r_duty;
    assign amp_num = {sp_used, 16'b0} + AMP_K'(geff >> 1);
    assign high_num = HIGH_K'(r_period * d_used);

    // in the direct tick path pulse mode is off, so the remainder is not used
    assign tick_code = !r_src_en ? '0 :
                       !r_pulse ? r_amp :
                       (div_rem < DW'(r_high)) ? r_amp : '0;

    assign smp_active = r_src_en && !r_inhibit && !r_pulse;
    assign abs_err = (DIFF_W'(r_target) >= DIFF_W'(r_meas))
                     ? DIFF_W'(r_target) - DIFF_W'(r_meas)
                     : DIFF_W'(r_meas) - DIFF_W'(r_target);
    assign smp_adj = r_comp_en && (32'(r_target) >= TMIN) && (64'(abs_err) > 64'(ETHR));
    assign gain_new = (div_quo > NW'(GAIN_HIGH)) ? GAIN_W'(GAIN_HIGH) :
                      (div_quo < NW'(GAIN_LOW))  ? GAIN_W'(GAIN_LOW)  :
                      div_quo[GAIN_W-1:0];

    assign out_free = !r_ovalid || !i_stall;
    assign idle_amp = (r_state == ST_IDLE) && r_amp_pend;
    assign idle_tim = (r_state == ST_IDLE) && !r_amp_pend && r_tim_pend;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        o_q_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_amp_pend) begin
                    n_state = ST_AMP_GO;
                end else if (r_tim_pend) begin
                    div_start = 1'b1;
                    div_num   = NW'(US_PER_S) << (NW - PER_K);
                    div_den   = DW'(f_used);
                    div_steps = SW'(PER_K);
                    n_state   = ST_PER_DIV;
                end else if (i_q_nonempty) begin
                    o_q_pop = 1'b1;
                    if (i_job.op == OP_TICK) begin
                        if (r_src_en && r_pulse) begin
                            div_start = 1'b1;
                            div_num   = NW'(i_job.time_us) << (NW - TIME_W);
                            div_den   = DW'(r_period);
                            div_steps = SW'(TIME_W);
                            n_state   = ST_TICK_DIV;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end else begin
                        n_state = smp_active ? ST_SMP_LOAD : ST_OUT;
                    end
                end
            end
            ST_AMP_GO: begin
                div_start = 1'b1;
                div_num   = NW'(amp_num) << (NW - AMP_K);
                div_den   = DW'(geff);
                div_steps = SW'(AMP_K);
                n_state   = ST_AMP_DIV;
            end
            ST_AMP_DIV: begin
                if (div_done) begin
                    n_state = r_ret_out ? ST_OUT : ST_IDLE;
                end
            end
            ST_PER_DIV: begin
                if (div_done) begin
                    n_state = ST_HIGH_GO;
                end
            end
            ST_HIGH_GO:  n_state = ST_HIGH_DIV;
            ST_HIGH_DIV: n_state = ST_IDLE;
            ST_TICK_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_SMP_LOAD:  n_state = ST_SMP_CHECK;
            ST_SMP_CHECK: n_state = smp_adj ? ST_SMP_MUL : ST_OUT;
            ST_SMP_MUL:   n_state = ST_SMP_SUM;
            ST_SMP_SUM: begin
                // rounded quotient: add half the divisor
                div_start = 1'b1;
                div_num   = (NW'(r_phi) << SPLIT) + NW'(r_plo) + NW'(r_den >> 1);
                div_den   = r_den;
                div_steps = SW'(NW);
                n_state   = ST_GAIN_DIV;
            end
            ST_GAIN_DIV: begin
                if (div_done) begin
                    n_state = ST_AMP_GO;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_setpoint <= '0;
            r_freq     <= FRQ_W'(1);
            r_duty     <= '0;
            r_pulse    <= 1'b0;
            r_src_en   <= 1'b0;
            r_comp_en  <= 1'b1;
            r_inhibit  <= 1'b0;
            r_gain     <= GAIN_W'(GAIN_ONE);
            r_amp      <= '0;
            r_last     <= '0;
            r_written  <= 1'b0;
            r_period   <= PER_W'(US_PER_S);
            r_high     <= '0;
            r_amp_pend <= 1'b0;
            r_tim_pend <= 1'b0;
            r_ret_out  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (idle_amp) begin
                r_amp_pend <= 1'b0;
                r_ret_out  <= 1'b0;
            end
            if (idle_tim) begin
                r_tim_pend <= 1'b0;
            end

            if (o_q_pop) begin
                r_total <= i_job.total;
                if (i_job.op == OP_TICK) begin
                    if (!(r_src_en && r_pulse)) begin
                        r_res_code  <= tick_code;
                        r_res_wr    <= !r_written || (tick_code != r_last);
                        r_last      <= tick_code;
                        r_written   <= 1'b1;
                        r_res_total <= '0;
                        r_res_adj   <= 1'b0;
                    end
                end else begin
                    r_res_code  <= r_last;
                    r_res_wr    <= 1'b0;
                    r_res_total <= '0;
                    r_res_adj   <= 1'b0;
                end
            end

            unique case (r_state)
                ST_AMP_DIV: begin
                    if (div_done) begin
                        r_amp <= (div_quo > NW'(DAC_MAX)) ? DAC_WIDTH'(DAC_MAX)
                                                          : div_quo[DAC_WIDTH-1:0];
                    end
                end
                ST_PER_DIV: begin
                    if (div_done) begin
                        r_period <= div_quo[PER_W-1:0];
                    end
                end
                ST_HIGH_GO: begin
                    r_high_num <= high_num;
                end
                ST_HIGH_DIV: begin
                    r_high <= PER_W'((64'(r_high_num) * DIV100_M) >> DIV100_S);
                end
                ST_TICK_DIV: begin
                    if (div_done) begin
                        r_res_code  <= tick_code;
                        r_res_wr    <= !r_written || (tick_code != r_last);
                        r_last      <= tick_code;
                        r_written   <= 1'b1;
                        r_res_total <= '0;
                        r_res_adj   <= 1'b0;
                    end
                end
                ST_SMP_LOAD: begin
                    r_target    <= TGT_W'(sp_used * TGT_K);
                    r_meas      <= MEAS_W'(64'(r_total) * 64'(MEAS_K));
                    r_res_total <= r_total;
                end
                ST_SMP_CHECK: begin
                    r_sum  <= SUM_W'(r_target) * SUM_W'(19) + SUM_W'(r_meas);
                    r_den  <= DW'(r_target) * DW'(20);
                    r_geff <= geff;
                end
                ST_SMP_MUL: begin
                    r_plo <= r_geff * r_sum[SPLIT-1:0];
                    r_phi <= r_geff * r_sum[SUM_W-1:SPLIT];
                end
                ST_GAIN_DIV: begin
                    if (div_done) begin
                        r_gain    <= gain_new;
                        r_ret_out <= 1'b1;
                        r_res_adj <= 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid        <= 1'b1;
                o_dac_code      <= r_res_code;
                o_dac_write     <= r_res_wr;
                o_gain_value    <= r_gain;
                o_total_current <= r_res_total;
                o_gain_adjusted <= r_res_adj;
            end

            // the user must write settings only while no item is in flight; the block itself does not enforce it
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SETPOINT: begin
                        r_setpoint <= i_cfg_data[SP_W-1:0];
                        r_amp_pend <= 1'b1;
                    end
                    CFG_FREQ: begin
                        r_freq     <= i_cfg_data[FRQ_W-1:0];
                        r_tim_pend <= 1'b1;
                    end
                    CFG_DUTY: begin
                        r_duty     <= i_cfg_data[DUTY_W-1:0];
                        r_tim_pend <= 1'b1;
                    end
                    CFG_PULSE: begin
                        r_pulse    <= i_cfg_data[0];
                        r_amp_pend <= 1'b1;
                    end
                    CFG_SRC_EN:  r_src_en  <= i_cfg_data[0];
                    CFG_COMP_EN: r_comp_en <= i_cfg_data[0];
                    CFG_INHIBIT: r_inhibit <= i_cfg_data[0];
                    CFG_GAIN_INIT: begin
                        r_gain     <= i_cfg_data[GAIN_W-1:0];
                        r_amp_pend <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;

endmodule

### tb/sv/tb_compensated_current_drive.sv
// ----------------------------------------------------------------------------
// tb_compensated_current_drive
// Self-checking bench: queued items driven with random gaps and output
// stalls, results compared against an in-bench model of the DAC drive.
// ----------------------------------------------------------------------------
module tb_compensated_current_drive;
    import ccd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DMAX = 4095;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] t;
        logic [15:0]       s1;
        logic [15:0]       s2;
    } item_t;

    typedef struct packed {
        logic [11:0]       code;
        logic              wr;
        logic [GAIN_W-1:0] gain;
        logic [TOT_W-1:0]  total;
        logic              adj;
    } drive_res_t;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_op = 0, i_stall = 0, i_cfg_we = 0;
    logic [TIME_W-1:0] i_time_us = '0;
    logic signed [RAW_W-1:0] i_shunt_one_raw = '0, i_shunt_two_raw = '0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_dac_write, o_gain_adjusted;
    logic [11:0] o_dac_code;
    logic [GAIN_W-1:0] o_gain_value;
    logic [TOT_W-1:0] o_total_current;

    compensated_current_drive i_dut (.*);

    always #1 i_clk = ~i_clk;

    // model state
    int unsigned m_sp, m_frq, m_duty, m_pulse, m_src, m_comp, m_inh, m_ginit;
    int unsigned m_gain, m_amp, m_last, m_written;

    item_t      pending_items[$];
    drive_res_t expected_drive[$];
    int idle_pct = 0, stall_pct = 0, hold_cycles = 0;
    int mismatches = 0, n_results = 0, n_adj = 0;

    function automatic int unsigned gain_used();
        return (m_gain > 32768 && m_gain < 98304) ? m_gain : GAIN_ONE;
    endfunction

    function automatic void refresh_amp();
        longint unsigned g, a;
        g = gain_used();
        a = (longint'(m_sp) * GAIN_ONE + g / 2) / g;
        m_amp = a > DMAX ? DMAX : a;
    endfunction

    function automatic void model_reset();
        m_sp = 0; m_frq = 1; m_duty = 0; m_pulse = 0; m_src = 0;
        m_comp = 1; m_inh = 0; m_ginit = GAIN_ONE; m_gain = GAIN_ONE;
        refresh_amp();
        m_last = 0; m_written = 0;
    endfunction

    function automatic int unsigned clip(logic [15:0] r);
        return r[15] ? 0 : r;
    endfunction

    function automatic drive_res_t predict_drive(item_t it);
        drive_res_t r;
        int unsigned f, d, per, hi, code;
        longint unsigned meas, tgt, den, num, g;
        longint er;
        r = '0;
        if (it.op == OP_TICK) begin
            code = 0;
            if (m_src != 0) begin
                code = m_amp;
                if (m_pulse != 0) begin
                    f = m_frq < 1 ? 1 : (m_frq > 100 ? 100 : m_frq);
                    d = m_duty > 100 ? 100 : m_duty;
                    per = US_PER_S / f;
                    hi = (longint'(per) * d) / 100;
                    code = (it.t % per) < hi ? m_amp : 0;
                end
            end
            r.wr = (m_written == 0 || code != m_last);
            m_last = code; m_written = 1;
            r.code = code;
        end else begin
            r.code = m_last;
            if (m_src != 0 && m_inh == 0 && m_pulse == 0) begin
                r.total = clip(it.s1) + clip(it.s2);
                meas = longint'(r.total) * 3 * DMAX;
                tgt = longint'(m_sp) * TGT_K;
                if (m_comp != 0 && tgt >= 100 * 16 * DMAX) begin
                    er = longint'(tgt) - longint'(meas);
                    if (er < 0) er = -er;
                    if (er > 20 * 16 * DMAX) begin
                        den = 20 * tgt;
                        num = longint'(gain_used()) * (19 * tgt + meas);
                        g = (num + den / 2) / den;
                        if (g < GAIN_LOW) g = GAIN_LOW;
                        if (g > GAIN_HIGH) g = GAIN_HIGH;
                        m_gain = g;
                        refresh_amp();
                        r.adj = 1;
                    end
                end
            end
        end
        r.gain = m_gain;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    item_t it;
                    it = pending_items.pop_front();
                    i_valid <= 1;
                    i_op <= it.op;
                    i_time_us <= it.t;
                    i_shunt_one_raw <= it.s1;
                    i_shunt_two_raw <= it.s2;
                    expected_drive.push_back(predict_drive(it));
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall, with long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            drive_res_t got, exp_r;
            got = '{o_dac_code, o_dac_write, o_gain_value, o_total_current,
                    o_gain_adjusted};
            n_results++;
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_drive.pop_front();
                if (exp_r.adj) n_adj++;
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp code=%0d wr=%0d gain=%0d tot=%0d adj=%0d | got code=%0d wr=%0d gain=%0d tot=%0d adj=%0d",
                            exp_r.code, exp_r.wr, exp_r.gain, exp_r.total, exp_r.adj,
                            got.code, got.wr, got.gain, got.total, got.adj);
                end
            end
        end
    end

    task automatic wait_drain();
        while (pending_items.size() > 0 || expected_drive.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int unsigned val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        case (idx)
            CFG_SETPOINT:  begin m_sp = val & 12'hFFF; refresh_amp(); end
            CFG_FREQ:      m_frq = val & 7'h7F;
            CFG_DUTY:      m_duty = val & 7'h7F;
            CFG_PULSE:     begin m_pulse = val & 1; refresh_amp(); end
            CFG_SRC_EN:    m_src = val & 1;
            CFG_COMP_EN:   m_comp = val & 1;
            CFG_INHIBIT:   m_inh = val & 1;
            CFG_GAIN_INIT: begin
                m_ginit = val & 17'h1FFFF; m_gain = m_ginit; refresh_amp();
            end
            default: ;
        endcase
    endtask

    function automatic item_t mk_tick(logic [31:0] t);
        return '{OP_TICK, t, 16'h0, 16'h0};
    endfunction

    // sample near the target current so adjustments stay plausible
    function automatic item_t mk_sample_near();
        int unsigned tgt_lsb, tot, a;
        tgt_lsb = (m_sp * 6600 * 16) / (3 * DMAX);
        tot = tgt_lsb + $urandom_range(400) - 200;
        if (tot > 60000) tot = 60000;
        a = $urandom_range(tot);
        return '{OP_SAMPLE, $urandom, 16'(a), 16'(tot - a)};
    endfunction

    function automatic item_t mk_random();
        item_t it;
        it = '{logic'($urandom_range(1)), $urandom, 16'($urandom), 16'($urandom)};
        return it;
    endfunction

    task automatic random_phase(int n, int ip, int sp);
        idle_pct = ip; stall_pct = sp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) pending_items.push_back(mk_random());
            else if ($urandom_range(1)) pending_items.push_back(mk_tick($urandom));
            else pending_items.push_back(mk_sample_near());
        end
        wait_drain();
    endtask

    initial begin
        int unsigned sps[4];
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, then extremes
        pending_items.push_back(mk_tick(0));
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h7FFF, 16'h8000});
        wait_drain();
        cfg_write(CFG_SRC_EN, 1);
        cfg_write(CFG_SETPOINT, 4095);
        pending_items.push_back(mk_tick(32'hFFFF_FFFF));
        pending_items.push_back(mk_tick(5));
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h7FFF, 16'h7FFF});
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h0, 16'h0});
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'hFFFF, 16'h8000});
        pending_items.push_back(mk_tick(7));
        wait_drain();
        cfg_write(CFG_GAIN_INIT, 131071);   // out of range, acts as unity
        pending_items.push_back(mk_tick(1));
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h100, 16'h100});
        wait_drain();
        cfg_write(CFG_GAIN_INIT, 0);
        cfg_write(CFG_SETPOINT, 20);         // below 100 mA target
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h7FFF, 16'h0});
        pending_items.push_back(mk_tick(2));
        wait_drain();
        cfg_write(CFG_INHIBIT, 1);
        cfg_write(CFG_SETPOINT, 2000);
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h10, 16'h10});
        wait_drain();
        cfg_write(CFG_INHIBIT, 0);
        cfg_write(CFG_COMP_EN, 0);
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h10, 16'h10});
        wait_drain();
        cfg_write(CFG_COMP_EN, 1);
        cfg_write(CFG_PULSE, 1);
        cfg_write(CFG_FREQ, 0);
        cfg_write(CFG_DUTY, 127);
        pending_items.push_back(mk_tick(999_999));
        pending_items.push_back('{OP_SAMPLE, 32'h0, 16'h10, 16'h10});
        wait_drain();
        cfg_write(CFG_FREQ, 127);
        cfg_write(CFG_DUTY, 50);
        pending_items.push_back(mk_tick(4999));
        pending_items.push_back(mk_tick(5000));
        pending_items.push_back(mk_tick(0));
        wait_drain();
        cfg_write(CFG_DUTY, 0);
        pending_items.push_back(mk_tick(0));
        wait_drain();

        // random phases over several settings
        sps = '{4095, 150, 2048, 900};
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_SETPOINT, sps[ph % 4]);
            cfg_write(CFG_PULSE, ph % 3 == 2);
            cfg_write(CFG_FREQ, $urandom_range(127));
            cfg_write(CFG_DUTY, $urandom_range(127));
            cfg_write(CFG_SRC_EN, ph != 5);
            cfg_write(CFG_COMP_EN, ph != 6);
            cfg_write(CFG_INHIBIT, ph == 7);
            cfg_write(CFG_GAIN_INIT, ph == 4 ? 32768 + $urandom_range(65535) : 65536);
            case (ph % 4)
                0: random_phase(60, 0, 0);
                1: random_phase(60, 70, 0);
                2: random_phase(60, 0, 70);
                default: random_phase(60, 11, 11);
            endcase
        end

        // long receiver hold-off while the sender keeps offering
        idle_pct = 0; stall_pct = 0;
        cfg_write(CFG_PULSE, 0);
        hold_cycles = 600;
        for (int k = 0; k < 20; k++) pending_items.push_back(mk_sample_near());
        wait_drain();

        $display("Covered ticks, samples, pulse and DC modes, %0d results, %0d gain updates.",
                 n_results, n_adj);
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
